>>> rtl/abd_pkg.sv
// Package for the adaptive beat detector: field widths, register indexes,
// register reset values, state codes and serial step counts.
// Has no dependencies; imported by adaptive_beat_detector_core.
package abd_pkg;

   // field widths
   localparam int TimeW   = 32;
   localparam int FreqW   = 14;
   localparam int MagW    = 24;
   localparam int RatioW  = 10;
   localparam int RefrW   = 16;
   localparam int CountW  = 10;
   localparam int LevelW  = 8;
   localparam int AvgW    = 32;
   localparam int FracW   = 8;
   localparam int ProdW   = AvgW + RatioW;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 16;

   // serial step counts
   localparam int DivSteps = AvgW;
   localparam int MulSteps = RatioW;
   localparam int StepW    = 5;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegFreqLimit   = 3'd0;
   localparam logic [CsrIdxW-1:0] RegMagRatio    = 3'd1;
   localparam logic [CsrIdxW-1:0] RegRefractory  = 3'd2;
   localparam logic [CsrIdxW-1:0] RegCountLimit  = 3'd3;
   localparam logic [CsrIdxW-1:0] RegCountRestart = 3'd4;
   localparam logic [CsrIdxW-1:0] RegFadeStart   = 3'd5;

   // register reset values
   localparam logic [FreqW-1:0]  FreqLimitReset    = 14'd150;
   localparam logic [RatioW-1:0] MagRatioReset     = 10'd294;
   localparam logic [RefrW-1:0]  RefractoryReset   = 16'd333;
   localparam logic [CountW-1:0] CountLimitReset   = 10'd500;
   localparam logic [CountW-1:0] CountRestartReset = 10'd100;
   localparam logic [LevelW-1:0] FadeStartReset    = 8'd100;

   // sequencer state codes
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StDiv  = 3'd1;
   localparam logic [2:0] StUpd  = 3'd2;
   localparam logic [2:0] StMul  = 3'd3;
   localparam logic [2:0] StFin  = 3'd4;

endpackage

>>> rtl/adaptive_beat_detector_core.sv
// Adaptive beat detector core: bit-serial running-average update and
// bit-serial ratio multiply with a beat and fade decision per transaction.
// Depends on abd_pkg.
//
// A pass inside the refractory window goes from accept straight to the finish state;
// an analyzed pass runs 32 divide steps, update, 10 multiply steps, then the decision.
// A new transaction is taken only in the idle state, once the last one has committed;
// the divider and multiplier work one bit per cycle; a waiting result blocks the commit.
// Reset (synchronous, active high): registers take their reset values, the
// average and last beat time go to zero, the count to one, the fade to zero.
module adaptive_beat_detector_core
   import abd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TimeW-1:0]   req_now_ms,
   input  logic [FreqW-1:0]   req_peak_freq_hz,
   input  logic [MagW-1:0]    req_low_band_mag,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LevelW-1:0]  rsp_brightness,
   output logic               rsp_beat,
   output logic               rsp_analyzed,
   output logic [MagW-1:0]    rsp_average_mag,
   // configuration port
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata
);

   // configuration registers
   logic [FreqW-1:0]  freq_limit_ff;
   logic [RatioW-1:0] mag_ratio_ff;
   logic [RefrW-1:0]  refractory_ff;
   logic [CountW-1:0] count_limit_ff;
   logic [CountW-1:0] count_restart_ff;
   logic [LevelW-1:0] fade_start_ff;

   // detector state
   logic [AvgW-1:0]   avg_ff, avg_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [TimeW-1:0]  last_beat_ff, last_beat_in;
   logic [LevelW-1:0] fade_ff, fade_in;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [StepW-1:0]  step_ff, step_in;

   // per-transaction working registers
   logic [TimeW-1:0]  now_ff, now_in;
   logic [FreqW-1:0]  freq_ff, freq_in;
   logic [MagW-1:0]   mag_ff, mag_in;
   logic              analyzed_ff, analyzed_in;
   logic              neg_ff, neg_in;
   logic [AvgW-1:0]   quo_ff, quo_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [CountW-1:0] divisor_ff, divisor_in;
   logic [RatioW-1:0] ratio_sh_ff, ratio_sh_in;
   logic [ProdW-1:0]  acc_ff, acc_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [LevelW-1:0] out_bright_ff, out_bright_in;
   logic              out_beat_ff, out_beat_in;
   logic              out_analyzed_ff, out_analyzed_in;
   logic [MagW-1:0]   out_avg_ff, out_avg_in;

   // combinational helpers
   logic              accept;
   logic              commit;
   logic [TimeW-1:0]  elapsed;
   logic [AvgW-1:0]   target;
   logic [CountW:0]   rem_sh;
   logic              rem_ge;
   logic [CountW:0]   count_inc;
   logic              beat;
   logic [LevelW-1:0] level;

   assign req_ready       = (state_ff == StIdle);
   assign accept          = req_valid && req_ready;
   assign commit          = (state_ff == StFin) && (!out_valid_ff || rsp_ready);
   assign rsp_valid       = out_valid_ff;
   assign rsp_brightness  = out_bright_ff;
   assign rsp_beat        = out_beat_ff;
   assign rsp_analyzed    = out_analyzed_ff;
   assign rsp_average_mag = out_avg_ff;

   // refractory check and divide setup
   assign elapsed = req_now_ms - last_beat_ff;
   assign target  = {req_low_band_mag, {FracW{1'b0}}};

   // one restoring divide step
   assign rem_sh = {rem_ff, quo_ff[AvgW-1]};
   assign rem_ge = (rem_sh >= {1'b0, divisor_ff});

   // count advance with restart
   assign count_inc = {1'b0, count_ff} + {{CountW{1'b0}}, 1'b1};

   // beat decision and fade
   assign beat  = analyzed_ff && (freq_ff < freq_limit_ff) &&
                  ({{(ProdW-MagW-2*FracW){1'b0}}, mag_ff, {(2*FracW){1'b0}}} > acc_ff);
   assign level = beat ? fade_start_ff : fade_ff;

   // next-state logic
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      now_in          = now_ff;
      freq_in         = freq_ff;
      mag_in          = mag_ff;
      analyzed_in     = analyzed_ff;
      neg_in          = neg_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      ratio_sh_in     = ratio_sh_ff;
      acc_in          = acc_ff;
      avg_in          = avg_ff;
      count_in        = count_ff;
      last_beat_in    = last_beat_ff;
      fade_in         = fade_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_bright_in   = out_bright_ff;
      out_beat_in     = out_beat_ff;
      out_analyzed_in = out_analyzed_ff;
      out_avg_in      = out_avg_ff;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               now_in      = req_now_ms;
               freq_in     = req_peak_freq_hz;
               mag_in      = req_low_band_mag;
               analyzed_in = (elapsed > {{(TimeW-RefrW){1'b0}}, refractory_ff});
               neg_in      = (target < avg_ff);
               quo_in      = (target < avg_ff) ? (avg_ff - target) : (target - avg_ff);
               rem_in      = '0;
               divisor_in  = (count_ff == '0) ? {{(CountW-1){1'b0}}, 1'b1} : count_ff;
               step_in     = StepW'(DivSteps - 1);
               state_in    = (elapsed > {{(TimeW-RefrW){1'b0}}, refractory_ff}) ?
                             StDiv : StFin;
            end
         end
         StDiv: begin
            quo_in = {quo_ff[AvgW-2:0], rem_ge};
            rem_in = rem_ge ? CountW'(rem_sh - {1'b0, divisor_ff}) : rem_sh[CountW-1:0];
            if (step_ff == '0) begin
               state_in = StUpd;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         StUpd: begin
            // quotient magnitude moves the average toward the target
            avg_in      = neg_ff ? (avg_ff - quo_ff) : (avg_ff + quo_ff);
            count_in    = (count_inc > {1'b0, count_limit_ff}) ? count_restart_ff :
                          count_inc[CountW-1:0];
            acc_in      = '0;
            ratio_sh_in = mag_ratio_ff;
            step_in     = StepW'(MulSteps - 1);
            state_in    = StMul;
         end
         StMul: begin
            // msb-first shift and add of the ratio bits
            acc_in      = {acc_ff[ProdW-2:0], 1'b0} +
                          (ratio_sh_ff[RatioW-1] ? {{RatioW{1'b0}}, avg_ff} : '0);
            ratio_sh_in = {ratio_sh_ff[RatioW-2:0], 1'b0};
            if (step_ff == '0) begin
               state_in = StFin;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         StFin: begin
            if (commit) begin
               if (beat) begin
                  last_beat_in = now_ff;
               end
               fade_in         = (level != '0) ? (level - 1'b1) : level;
               out_valid_in    = 1'b1;
               out_bright_in   = level;
               out_beat_in     = beat;
               out_analyzed_in = analyzed_ff;
               out_avg_in      = avg_ff[AvgW-1:FracW];
               state_in        = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // control, configuration and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StIdle;
         out_valid_ff     <= 1'b0;
         avg_ff           <= '0;
         count_ff         <= {{(CountW-1){1'b0}}, 1'b1};
         last_beat_ff     <= '0;
         fade_ff          <= '0;
         freq_limit_ff    <= FreqLimitReset;
         mag_ratio_ff     <= MagRatioReset;
         refractory_ff    <= RefractoryReset;
         count_limit_ff   <= CountLimitReset;
         count_restart_ff <= CountRestartReset;
         fade_start_ff    <= FadeStartReset;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         avg_ff       <= avg_in;
         count_ff     <= count_in;
         last_beat_ff <= last_beat_in;
         fade_ff      <= fade_in;
         if (csr_we) begin
            unique case (csr_index)
               RegFreqLimit:    freq_limit_ff    <= csr_wdata[FreqW-1:0];
               RegMagRatio:     mag_ratio_ff     <= csr_wdata[RatioW-1:0];
               RegRefractory:   refractory_ff    <= csr_wdata[RefrW-1:0];
               RegCountLimit:   count_limit_ff   <= csr_wdata[CountW-1:0];
               RegCountRestart: count_restart_ff <= csr_wdata[CountW-1:0];
               RegFadeStart:    fade_start_ff    <= csr_wdata[LevelW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      step_ff         <= step_in;
      now_ff          <= now_in;
      freq_ff         <= freq_in;
      mag_ff          <= mag_in;
      analyzed_ff     <= analyzed_in;
      neg_ff          <= neg_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      divisor_ff      <= divisor_in;
      ratio_sh_ff     <= ratio_sh_in;
      acc_ff          <= acc_in;
      out_bright_ff   <= out_bright_in;
      out_beat_ff     <= out_beat_in;
      out_analyzed_ff <= out_analyzed_in;
      out_avg_ff      <= out_avg_in;
   end

endmodule

>>> dv/adaptive_beat_detector_core_tb.sv
// Self-checking testbench for adaptive_beat_detector_core: directed table plus
// random loop passes over several register settings, checked by a predictor.
// Depends on abd_pkg and the core RTL only.
`timescale 1ns / 100ps

module adaptive_beat_detector_core_tb;
   import abd_pkg::*;

   // result fields of one pass
   typedef struct packed {
      logic [LevelW-1:0] brightness;
      logic              beat;
      logic              analyzed;
      logic [MagW-1:0]   average_mag;
   } beat_result_type;

   // one row of the directed table
   typedef struct packed {
      logic [TimeW-1:0] now_ms;
      logic [FreqW-1:0] freq;
      logic [MagW-1:0]  mag;
      logic             typed;
      beat_result_type  want;
   } pass_row_type;

   // one register setting
   typedef struct packed {
      logic [FreqW-1:0]  freq_limit;
      logic [RatioW-1:0] ratio;
      logic [RefrW-1:0]  refr;
      logic [CountW-1:0] cnt_limit;
      logic [CountW-1:0] cnt_restart;
      logic [LevelW-1:0] fade;
   } reg_set_type;

   localparam logic [CsrIdxW-1:0] RegUnusedLo = 3'd6;
   localparam logic [CsrIdxW-1:0] RegUnusedHi = 3'd7;
   localparam int PhaseCount     = 8;
   localparam int RandomPerPhase = 206;
   localparam int DirectedCount  = 18;
   localparam beat_result_type NoResult = '0;

   // directed passes under reset settings; typed rows carry their own result
   localparam pass_row_type DirectedRows [DirectedCount] = '{
      '{32'd0,           14'd0,     24'd0,        1'b1, '{8'd0, 1'b0, 1'b0, 24'd0}},
      '{32'd333,         14'd12500, 24'hFFFFFF,   1'b1, '{8'd0, 1'b0, 1'b0, 24'd0}},
      '{32'd334,         14'd0,     24'd1000,     1'b1, '{8'd0, 1'b0, 1'b1, 24'd1000}},
      '{32'd335,         14'd149,   24'hFFFFFF,   1'b0, NoResult},
      '{32'd336,         14'd0,     24'd0,        1'b0, NoResult},
      '{32'd668,         14'd0,     24'd0,        1'b0, NoResult},
      '{32'd669,         14'd150,   24'hFFFFFF,   1'b0, NoResult},
      '{32'd1100,        14'd12500, 24'hFFFFFF,   1'b0, NoResult},
      '{32'd1500,        14'd0,     24'd0,        1'b0, NoResult},
      '{32'd2000,        14'd0,     24'd1,        1'b0, NoResult},
      '{32'hFFFF_FF00,   14'd0,     24'hFFFFFF,   1'b0, NoResult},
      '{32'hFFFF_FFFF,   14'd100,   24'h800000,   1'b0, NoResult},
      '{32'h0000_0010,   14'd0,     24'hFFFFFF,   1'b0, NoResult},
      '{32'h0000_0200,   14'd0,     24'hFFFFFF,   1'b0, NoResult},
      '{32'h5555_5555,   14'h2AAA,  24'h555555,   1'b0, NoResult},
      '{32'hAAAA_AAAA,   14'h1555,  24'hAAAAAA,   1'b0, NoResult},
      '{32'hAAAA_AAAA,   14'd0,     24'd0,        1'b0, NoResult},
      '{32'hAAAA_AD00,   14'd0,     24'd7,        1'b0, NoResult}
   };

   // settings for phases 1 to 6; phase 7 is random
   localparam reg_set_type PhaseRegs [PhaseCount-2] = '{
      '{14'd12500, 10'd256,  16'd0,     10'd2,    10'd0,    8'd255},
      '{14'd0,     10'd1023, 16'd65535, 10'd1023, 10'd1023, 8'd0},
      '{14'd150,   10'd294,  16'd333,   10'd500,  10'd100,  8'd100},
      '{14'd2000,  10'd300,  16'd50,    10'd10,   10'd1,    8'd8},
      '{14'd12500, 10'd1023, 16'd1,     10'd1023, 10'd1,    8'd255},
      '{14'd8000,  10'd400,  16'd200,   10'd3,    10'd3,    8'd30}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [TimeW-1:0]   req_now_ms;
   logic [FreqW-1:0]   req_peak_freq_hz;
   logic [MagW-1:0]    req_low_band_mag;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [LevelW-1:0]  rsp_brightness;
   logic               rsp_beat;
   logic               rsp_analyzed;
   logic [MagW-1:0]    rsp_average_mag;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDatW-1:0] csr_wdata;

   // predictor copy of registers and state
   logic [FreqW-1:0]  cfg_freq_limit;
   logic [RatioW-1:0] cfg_ratio;
   logic [RefrW-1:0]  cfg_refr;
   logic [CountW-1:0] cfg_cnt_limit;
   logic [CountW-1:0] cfg_cnt_restart;
   logic [LevelW-1:0] cfg_fade_start;
   logic [AvgW-1:0]   avg_q8;
   logic [CountW-1:0] smp_count;
   logic [TimeW-1:0]  last_beat;
   logic [LevelW-1:0] fade;

   beat_result_type pending_results [$];
   beat_result_type got;
   beat_result_type want_head;
   int           error_count = 0;
   int           stall_left = 0;
   bit           calm = 1'b0;
   logic [TimeW-1:0] clock_ms;
   int unsigned  base_mag;

   adaptive_beat_detector_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ms       (req_now_ms),
      .req_peak_freq_hz (req_peak_freq_hz),
      .req_low_band_mag (req_low_band_mag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_brightness   (rsp_brightness),
      .rsp_beat         (rsp_beat),
      .rsp_analyzed     (rsp_analyzed),
      .rsp_average_mag  (rsp_average_mag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // random gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (calm || r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // predictor reset state
   function automatic void clear_model();
      cfg_freq_limit  = FreqLimitReset;
      cfg_ratio       = MagRatioReset;
      cfg_refr        = RefractoryReset;
      cfg_cnt_limit   = CountLimitReset;
      cfg_cnt_restart = CountRestartReset;
      cfg_fade_start  = FadeStartReset;
      avg_q8          = '0;
      smp_count       = {{(CountW-1){1'b0}}, 1'b1};
      last_beat       = '0;
      fade            = '0;
   endfunction

   // register write as the block sees it; unknown indexes do nothing
   function automatic void apply_reg(input logic [CsrIdxW-1:0] idx,
                                     input logic [CsrDatW-1:0] data);
      case (idx)
         RegFreqLimit:    cfg_freq_limit  = data[FreqW-1:0];
         RegMagRatio:     cfg_ratio       = data[RatioW-1:0];
         RegRefractory:   cfg_refr        = data[RefrW-1:0];
         RegCountLimit:   cfg_cnt_limit   = data[CountW-1:0];
         RegCountRestart: cfg_cnt_restart = data[CountW-1:0];
         RegFadeStart:    cfg_fade_start  = data[LevelW-1:0];
         default: ;
      endcase
   endfunction

   // one loop pass: running average, beat decision and fade
   function automatic beat_result_type predict_pass(input logic [TimeW-1:0] now,
                                                    input logic [FreqW-1:0] freq,
                                                    input logic [MagW-1:0]  mag);
      logic [TimeW-1:0]  elapsed;
      longint            target;
      longint            diff;
      longint            divisor;
      longint            nxt;
      logic [CountW:0]   cnt;
      logic [63:0]       lhs;
      logic [63:0]       rhs;
      beat_result_type   r;
      bit                hit;
      elapsed = now - last_beat;
      r = '0;
      hit = 1'b0;
      r.analyzed = elapsed > {16'd0, cfg_refr};
      if (r.analyzed) begin
         // mean moves toward the magnitude, division truncates toward zero
         target  = longint'(mag) * 256;
         diff    = target - longint'(avg_q8);
         divisor = (smp_count == 0) ? 64'sd1 : longint'(smp_count);
         nxt     = longint'(avg_q8) + diff / divisor;
         if (nxt < 0) nxt = 0;
         if (nxt > 64'sh0000_0000_FFFF_FFFF) nxt = 64'sh0000_0000_FFFF_FFFF;
         avg_q8 = nxt[AvgW-1:0];
         cnt = {1'b0, smp_count} + 1'b1;
         if (cnt > {1'b0, cfg_cnt_limit}) cnt = {1'b0, cfg_cnt_restart};
         smp_count = cnt[CountW-1:0];
         // exact ratio compare in 64 bits
         lhs = {24'd0, mag, 16'd0};
         rhs = {32'd0, avg_q8} * {54'd0, cfg_ratio};
         hit = (freq < cfg_freq_limit) && (lhs > rhs);
      end
      if (hit) begin
         fade = cfg_fade_start;
         last_beat = now;
      end
      r.brightness = fade;
      if (fade > 0) fade = fade - 1'b1;
      r.beat = hit;
      r.average_mag = avg_q8[AvgW-1:FracW];
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp_val,
                              input longint act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // drive one pass and hold it until the transaction is accepted
   task automatic send_pass(input logic [TimeW-1:0] now, input logic [FreqW-1:0] freq,
                            input logic [MagW-1:0] mag, input bit typed,
                            input beat_result_type want);
      beat_result_type pred;
      req_valid        <= 1'b1;
      req_now_ms       <= now;
      req_peak_freq_hz <= freq;
      req_low_band_mag <= mag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = predict_pass(now, freq, mag);
      pending_results.push_back(typed ? want : pred);
   endtask

   // sender gap after a transaction, with occasional switches to no idling
   task automatic sender_gap();
      int gap;
      if ($urandom_range(99, 0) < 3) calm = !calm;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
   endtask

   // program all registers, with junk above each field narrower than the data word, and unused indexes
   task automatic program_regs(input reg_set_type s);
      logic [CsrDatW-1:0] noise;
      noise = CsrDatW'($urandom());
      write_reg(RegUnusedLo, noise);
      write_reg(RegFreqLimit, {noise[15:14], s.freq_limit});
      write_reg(RegMagRatio, {noise[15:10], s.ratio});
      write_reg(RegRefractory, s.refr);
      write_reg(RegCountLimit, {noise[9:4], s.cnt_limit});
      write_reg(RegCountRestart, {noise[5:0], s.cnt_restart});
      write_reg(RegFadeStart, {noise[7:0], s.fade});
      write_reg(RegUnusedHi, ~noise);
      csr_we <= 1'b0;
   endtask

   // random pass: mostly steady time steps and a noisy baseline with spikes
   task automatic random_pass();
      int     r;
      longint big;
      logic [FreqW-1:0] freq;
      logic [MagW-1:0]  mag;
      r = $urandom_range(99, 0);
      if (r < 3)
         clock_ms = $urandom();
      else if (r < 5)
         clock_ms = 32'hFFFF_FFFF - $urandom_range(2 * cfg_refr + 100, 0);
      else
         clock_ms = clock_ms + $urandom_range(2 * cfg_refr + 20, 0);
      r = $urandom_range(99, 0);
      if (r < 5) begin
         mag = MagW'($urandom());
      end else if (r < 8) begin
         mag = '1;
      end else if (r < 10) begin
         mag = '0;
      end else begin
         if (r < 28)
            big = longint'(base_mag) * longint'($urandom_range(4, 2));
         else
            big = longint'(base_mag) + longint'($urandom_range(base_mag / 4, 0))
                  - longint'(base_mag / 8);
         if (big < 0) big = 0;
         if (big > 64'sd16777215) big = 64'sd16777215;
         mag = big[MagW-1:0];
      end
      if ($urandom_range(99, 0) < 65 && cfg_freq_limit > 0)
         freq = FreqW'($urandom_range(cfg_freq_limit - 1, 0));
      else
         freq = FreqW'($urandom_range(12500, 0));
      send_pass(clock_ms, freq, mag, 1'b0, NoResult);
   endtask

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_brightness, rsp_beat, rsp_analyzed, rsp_average_mag};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want_head = pending_results.pop_front();
            check_field("brightness", want_head.brightness, got.brightness);
            check_field("beat", want_head.beat, got.beat);
            check_field("analyzed", want_head.analyzed, got.analyzed);
            check_field("average_mag", want_head.average_mag, got.average_mag);
         end
      end
   end

   initial begin
      reg_set_type s;
      int       waited;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_ms       = '0;
      req_peak_freq_hz = '0;
      req_low_band_mag = '0;
      rsp_ready        = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      clock_ms         = '0;
      clear_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         // registers change only with the block idle
         if (phase > 0) begin
            while (pending_results.size() != 0) @(posedge clock);
            repeat (4) @(posedge clock);
            if (phase < PhaseCount - 1) begin
               s = PhaseRegs[phase - 1];
            end else begin
               s.freq_limit  = FreqW'($urandom_range(12500, 0));
               s.ratio       = RatioW'($urandom_range(1023, 256));
               s.refr        = RefrW'($urandom_range(2000, 0));
               s.cnt_limit   = CountW'($urandom_range(1023, 2));
               s.cnt_restart = CountW'($urandom_range(1023, 1));
               s.fade        = LevelW'($urandom_range(255, 0));
            end
            program_regs(s);
         end
         case ($urandom_range(2, 0))
            0: base_mag = $urandom_range(1000, 10);
            1: base_mag = $urandom_range(100000, 1000);
            default: base_mag = $urandom_range(4000000, 100000);
         endcase
         if (phase == 0) begin
            for (int i = 0; i < DirectedCount; i++) begin
               send_pass(DirectedRows[i].now_ms, DirectedRows[i].freq, DirectedRows[i].mag,
                         DirectedRows[i].typed, DirectedRows[i].want);
               sender_gap();
            end
            clock_ms = DirectedRows[DirectedCount - 1].now_ms;
         end
         for (int i = 0; i < RandomPerPhase; i++) begin
            random_pass();
            sender_gap();
         end
         req_valid <= 1'b0;
      end

      // drain and let any stray result show up
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: missing results: expected 0 pending, actual %0d",
                  $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
